// ===== hw/rtl/pat_pkg.sv =====
// shared types, constants and functions of the primitive assembly unit
package pat_pkg;

   localparam int WORD_WIDTH   = 32;
   localparam int VERTEX_WORDS = 9;
   localparam int STORE_SLOTS  = 3;
   localparam int EMIT_SLOTS   = 4;

   typedef logic [1:0] slot_idx_type;
   typedef logic [2:0] step_type;

   localparam step_type LAST_STEP_TRI  = 3'd2;
   localparam step_type LAST_STEP_QUAD = 3'd5;

   typedef enum logic [1:0] {
      MODE_NONE      = 2'd0,
      MODE_TRIANGLES = 2'd1,
      MODE_STRIP     = 2'd2,
      MODE_QUADS     = 2'd3
   } mode_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] x;
      logic [WORD_WIDTH-1:0] y;
      logic [WORD_WIDTH-1:0] z;
      logic [WORD_WIDTH-1:0] u;
      logic [WORD_WIDTH-1:0] v;
      logic [WORD_WIDTH-1:0] red;
      logic [WORD_WIDTH-1:0] green;
      logic [WORD_WIDTH-1:0] blue;
      logic [WORD_WIDTH-1:0] alpha;
   } vertex_type;

   // one assembled triangle group handed to the output sequencer
   typedef struct packed {
      logic       valid;
      logic       quad;
      vertex_type v0;
      vertex_type v1;
      vertex_type v2;
      vertex_type v3;
   } launch_type;

   // buffer slot sent at each step: quads 0,1,2,0,2,3 and triangles 0,1,3
   function automatic slot_idx_type seq_slot(input step_type step, input logic quad);
      slot_idx_type sel;
      sel = 2'd3;
      if (quad) begin
         case (step)
            3'd0:    sel = 2'd0;
            3'd1:    sel = 2'd1;
            3'd2:    sel = 2'd2;
            3'd3:    sel = 2'd0;
            3'd4:    sel = 2'd2;
            default: sel = 2'd3;
         endcase
      end else begin
         case (step)
            3'd0:    sel = 2'd0;
            3'd1:    sel = 2'd1;
            default: sel = 2'd3;
         endcase
      end
      return sel;
   endfunction

endpackage

// ===== hw/rtl/pat_vertex_if.sv =====
// input vertex channel
interface pat_vertex_if import pat_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  first_vertex;
   logic [WORD_WIDTH-1:0] pos_x;
   logic [WORD_WIDTH-1:0] pos_y;
   logic [WORD_WIDTH-1:0] pos_z;
   logic [WORD_WIDTH-1:0] tex_u;
   logic [WORD_WIDTH-1:0] tex_v;
   logic [WORD_WIDTH-1:0] color_red;
   logic [WORD_WIDTH-1:0] color_green;
   logic [WORD_WIDTH-1:0] color_blue;
   logic [WORD_WIDTH-1:0] color_alpha;

   modport source (
      output valid, first_vertex, pos_x, pos_y, pos_z, tex_u, tex_v,
             color_red, color_green, color_blue, color_alpha,
      input  ready
   );
   modport sink (
      input  valid, first_vertex, pos_x, pos_y, pos_z, tex_u, tex_v,
             color_red, color_green, color_blue, color_alpha,
      output ready
   );
endinterface

// ===== hw/rtl/pat_tri_if.sv =====
// triangle vertex result channel
interface pat_tri_if import pat_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] out_x;
   logic [WORD_WIDTH-1:0] out_y;
   logic [WORD_WIDTH-1:0] out_z;
   logic [WORD_WIDTH-1:0] out_u;
   logic [WORD_WIDTH-1:0] out_v;
   logic [WORD_WIDTH-1:0] out_red;
   logic [WORD_WIDTH-1:0] out_green;
   logic [WORD_WIDTH-1:0] out_blue;
   logic [WORD_WIDTH-1:0] out_alpha;
   logic                  last_of_run;

   modport source (
      output valid, out_x, out_y, out_z, out_u, out_v, out_red, out_green,
             out_blue, out_alpha, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, out_u, out_v, out_red, out_green,
             out_blue, out_alpha, last_of_run,
      output ready
   );
endinterface

// ===== hw/rtl/pat_csr_if.sv =====
// mode register write channel
interface pat_csr_if import pat_pkg::*; ();
   logic     valid;
   logic     ready;
   mode_type assembly_mode;

   modport source (output valid, assembly_mode, input ready);
   modport sink (input valid, assembly_mode, output ready);
endinterface

// ===== hw/rtl/primitive_assembly_to_triangles_unit.sv =====
// primitive assembly top level: vertex stream in, triangle vertex stream out
//
//   channel  dir  handshake      word
//   req_ch   in   valid/ready    one vertex plus first_vertex flag
//   rsp_ch   out  valid/ready    one triangle vertex plus last_of_run
//   csr_ch   in   valid/ready    assembly_mode, always ready
//
// a vertex that completes no triangle is only stored, and is taken whenever the result buffer can take a launch
// a triangle is sent as three words, a quad as six, one word per cycle from the result buffer while rsp_ch is ready
// the next vertex is taken in the cycle the last word of a run leaves
// reset clears the mode to none and empties the assembly and result buffer
// an output stall holds the buffer and stalls the input only while it is full
module primitive_assembly_to_triangles_unit import pat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pat_vertex_if.sink req_ch,
   pat_tri_if.source  rsp_ch,
   pat_csr_if.sink    csr_ch
);

   launch_type launch;
   logic       launch_ready;

   pat_assemble u_assemble (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .csr_ch       (csr_ch),
      .launch_ready (launch_ready),
      .launch       (launch)
   );

   pat_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .launch       (launch),
      .launch_ready (launch_ready),
      .rsp_ch       (rsp_ch)
   );

endmodule

// ===== hw/rtl/pat_assemble.sv =====
// vertex store, assembly count and strip winding state
module pat_assemble import pat_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pat_vertex_if.sink    req_ch,
   pat_csr_if.sink       csr_ch,
   input  logic          launch_ready,
   output launch_type    launch
);

   mode_type     mode_ff;
   slot_idx_type count_ff, count_in;
   logic         odd_ff, odd_in;
   vertex_type   slot_ff [STORE_SLOTS];
   vertex_type   slot_in [STORE_SLOTS];

   vertex_type   cur;
   slot_idx_type count_eff;
   logic         odd_eff;
   logic         accept;

   assign req_ch.ready = launch_ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;

   assign cur = '{x: req_ch.pos_x, y: req_ch.pos_y, z: req_ch.pos_z,
                  u: req_ch.tex_u, v: req_ch.tex_v,
                  red: req_ch.color_red, green: req_ch.color_green,
                  blue: req_ch.color_blue, alpha: req_ch.color_alpha};

   // a first vertex restarts assembly before it is taken
   assign count_eff = req_ch.first_vertex ? 2'd0 : count_ff;
   assign odd_eff   = req_ch.first_vertex ? 1'b0 : odd_ff;

   always_comb begin
      count_in = count_ff;
      odd_in   = odd_ff;
      for (int s = 0; s < STORE_SLOTS; s++) begin
         slot_in[s] = slot_ff[s];
      end
      launch       = '0;
      launch.v0    = slot_ff[0];
      launch.v1    = slot_ff[1];
      launch.v2    = cur;
      launch.v3    = cur;
      if (accept) begin
         count_in = count_eff;
         odd_in   = odd_eff;
         unique case (mode_ff)
            MODE_TRIANGLES: begin
               if (count_eff < 2'd2) begin
                  slot_in[count_eff] = cur;
                  count_in           = count_eff + 2'd1;
               end else begin
                  launch.valid = 1'b1;
                  count_in     = 2'd0;
               end
            end
            MODE_QUADS: begin
               if (count_eff < 2'd3) begin
                  slot_in[count_eff] = cur;
                  count_in           = count_eff + 2'd1;
               end else begin
                  launch.valid = 1'b1;
                  launch.quad  = 1'b1;
                  launch.v2    = slot_ff[2];
                  count_in     = 2'd0;
               end
            end
            MODE_STRIP: begin
               if (count_eff < 2'd2) begin
                  slot_in[count_eff] = cur;
                  count_in           = count_eff + 2'd1;
               end else begin
                  launch.valid = 1'b1;
                  if (odd_eff) begin
                     launch.v0 = slot_ff[1];
                     launch.v1 = slot_ff[0];
                  end
                  odd_in     = !odd_eff;
                  slot_in[0] = slot_ff[1];
                  slot_in[1] = cur;
                  count_in   = 2'd2;
               end
            end
            MODE_NONE: begin
               count_in = count_eff;
            end
            default: begin
               count_in = count_eff;
            end
         endcase
      end
      // a mode write starts a new primitive
      if (csr_ch.valid) begin
         count_in = 2'd0;
         odd_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NONE;
         count_ff <= 2'd0;
         odd_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         odd_ff   <= odd_in;
         if (csr_ch.valid) begin
            mode_ff <= csr_ch.assembly_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STORE_SLOTS; s++) begin
         slot_ff[s] <= slot_in[s];
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3 || mode_ff == MODE_QUADS)
      else $error("three held vertices outside quad mode");

   a_strip_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_ch.valid && mode_ff == MODE_STRIP && count_eff == 2'd2
      |=> count_ff == 2'd2 && odd_ff != $past(odd_eff))
      else $error("strip did not keep two vertices or flip winding");

endmodule

// ===== hw/rtl/pat_emit.sv =====
// result buffer and sequencer sending one triangle vertex per word
module pat_emit import pat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  launch_type launch,
   output logic       launch_ready,
   pat_tri_if.source  rsp_ch
);

   logic         busy_ff, busy_in;
   step_type     step_ff, step_in;
   logic         quad_ff;
   vertex_type   vtx_ff [EMIT_SLOTS];

   logic         last;
   logic         taken;
   vertex_type   sel_vtx;

   assign last         = step_ff == (quad_ff ? LAST_STEP_QUAD : LAST_STEP_TRI);
   assign taken        = busy_ff && rsp_ch.ready;
   assign launch_ready = !busy_ff || (taken && last);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (taken) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
         end
      end
      if (launch.valid) begin
         busy_in = 1'b1;
         step_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (launch.valid) begin
         quad_ff   <= launch.quad;
         vtx_ff[0] <= launch.v0;
         vtx_ff[1] <= launch.v1;
         vtx_ff[2] <= launch.v2;
         vtx_ff[3] <= launch.v3;
      end
   end

   assign sel_vtx            = vtx_ff[seq_slot(step_ff, quad_ff)];
   assign rsp_ch.valid       = busy_ff;
   assign rsp_ch.out_x       = sel_vtx.x;
   assign rsp_ch.out_y       = sel_vtx.y;
   assign rsp_ch.out_z       = sel_vtx.z;
   assign rsp_ch.out_u       = sel_vtx.u;
   assign rsp_ch.out_v       = sel_vtx.v;
   assign rsp_ch.out_red     = sel_vtx.red;
   assign rsp_ch.out_green   = sel_vtx.green;
   assign rsp_ch.out_blue    = sel_vtx.blue;
   assign rsp_ch.out_alpha   = sel_vtx.alpha;
   assign rsp_ch.last_of_run = last;

   a_launch_free: assert property (@(posedge clock) disable iff (reset)
      launch.valid |-> launch_ready)
      else $error("triangle group launched over a busy buffer");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= LAST_STEP_QUAD)
      else $error("sequencer step out of range");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      taken && last && !launch.valid |=> !busy_ff)
      else $error("buffer still busy after last word of a run");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the primitive assembly unit: every mode against a triangle predictor
module tb_top;
   import pat_pkg::*;

   localparam int SETTLE_CYCLES    = 8;
   localparam int HOLD_AFTER_WORDS = 120;
   localparam int HOLD_CYCLES      = 200;
   localparam int PHASE_VERTICES   = 63;
   localparam int RANDOM_PHASES    = 11;

   typedef struct packed {
      logic       first;
      vertex_type vert;
   } vertex_item_type;

   typedef struct packed {
      vertex_type vert;
      logic       last;
   } tri_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pat_vertex_if req_ch();
   pat_tri_if    rsp_ch();
   pat_csr_if    csr_ch();

   primitive_assembly_to_triangles_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // vertex sender and result receiver state
   vertex_item_type vertices_to_send [$];
   vertex_item_type send_item  = '0;
   logic            send_valid = 1'b0;
   int              send_gap   = 0;
   bit              send_quiet = 1'b0;
   logic            req_taken  = 1'b0;

   logic            take_ready = 1'b0;
   int              take_gap   = 0;
   bit              take_quiet = 1'b0;
   logic            rsp_taken  = 1'b0;
   int              hold_left  = 0;
   bit              hold_done  = 1'b0;

   // triangle predictor state
   mode_type        asm_mode   = MODE_NONE;
   vertex_type      held_verts [STORE_SLOTS];
   int              held_count = 0;
   bit              strip_swap = 1'b0;
   tri_word_type    triangle_words_due [$];

   int              mismatches     = 0;
   int              words_seen     = 0;
   int              vertices_taken = 0;
   int              modes_written  = 0;

   assign req_ch.valid        = send_valid;
   assign req_ch.first_vertex = send_item.first;
   assign req_ch.pos_x        = send_item.vert.x;
   assign req_ch.pos_y        = send_item.vert.y;
   assign req_ch.pos_z        = send_item.vert.z;
   assign req_ch.tex_u        = send_item.vert.u;
   assign req_ch.tex_v        = send_item.vert.v;
   assign req_ch.color_red    = send_item.vert.red;
   assign req_ch.color_green  = send_item.vert.green;
   assign req_ch.color_blue   = send_item.vert.blue;
   assign req_ch.color_alpha  = send_item.vert.alpha;
   assign rsp_ch.ready        = take_ready;

   initial forever #5 clock = ~clock;

   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 24) == 0)
         quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic logic [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type vert;
      vert.x     = pick_word();
      vert.y     = pick_word();
      vert.z     = pick_word();
      vert.u     = pick_word();
      vert.v     = pick_word();
      vert.red   = pick_word();
      vert.green = pick_word();
      vert.blue  = pick_word();
      vert.alpha = pick_word();
      return vert;
   endfunction

   task automatic queue_vertex(input logic first, input vertex_type vert);
      vertices_to_send.push_back('{first: first, vert: vert});
   endtask

   task automatic queue_word(input vertex_type vert, input logic last);
      triangle_words_due.push_back('{vert: vert, last: last});
   endtask

   task automatic assemble_vertex(input vertex_item_type item);
      if (item.first) begin
         held_count = 0;
         strip_swap = 1'b0;
      end
      case (asm_mode)
         MODE_TRIANGLES: begin
            if (held_count < 2) begin
               held_verts[held_count] = item.vert;
               held_count++;
            end else begin
               queue_word(held_verts[0], 1'b0);
               queue_word(held_verts[1], 1'b0);
               queue_word(item.vert, 1'b1);
               held_count = 0;
            end
         end
         MODE_QUADS: begin
            if (held_count < 3) begin
               held_verts[held_count] = item.vert;
               held_count++;
            end else begin
               queue_word(held_verts[0], 1'b0);
               queue_word(held_verts[1], 1'b0);
               queue_word(held_verts[2], 1'b0);
               queue_word(held_verts[0], 1'b0);
               queue_word(held_verts[2], 1'b0);
               queue_word(item.vert, 1'b1);
               held_count = 0;
            end
         end
         MODE_STRIP: begin
            if (held_count < 2) begin
               held_verts[held_count] = item.vert;
               held_count++;
            end else begin
               // swap keeps the winding on every second triangle
               queue_word(held_verts[strip_swap ? 1 : 0], 1'b0);
               queue_word(held_verts[strip_swap ? 0 : 1], 1'b0);
               queue_word(item.vert, 1'b1);
               strip_swap    = !strip_swap;
               held_verts[0] = held_verts[1];
               held_verts[1] = item.vert;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [WORD_WIDTH-1:0] want,
                              input logic [WORD_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s expected %h actual %h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_triangle_word();
      tri_word_type want;
      words_seen++;
      if (triangle_words_due.size() == 0) begin
         $error("triangle vertex with none expected, out_x %h", rsp_ch.out_x);
         mismatches++;
      end else begin
         want = triangle_words_due.pop_front();
         check_field("out_x", want.vert.x, rsp_ch.out_x);
         check_field("out_y", want.vert.y, rsp_ch.out_y);
         check_field("out_z", want.vert.z, rsp_ch.out_z);
         check_field("out_u", want.vert.u, rsp_ch.out_u);
         check_field("out_v", want.vert.v, rsp_ch.out_v);
         check_field("out_red", want.vert.red, rsp_ch.out_red);
         check_field("out_green", want.vert.green, rsp_ch.out_green);
         check_field("out_blue", want.vert.blue, rsp_ch.out_blue);
         check_field("out_alpha", want.vert.alpha, rsp_ch.out_alpha);
         check_field("last_of_run", WORD_WIDTH'(want.last),
                     WORD_WIDTH'(rsp_ch.last_of_run));
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready)
            check_triangle_word();
         if (csr_ch.valid && csr_ch.ready) begin
            asm_mode   = csr_ch.assembly_mode;
            held_count = 0;
            strip_swap = 1'b0;
            modes_written++;
         end
         if (req_ch.valid && req_ch.ready) begin
            vertices_taken++;
            assemble_vertex('{first: req_ch.first_vertex,
                              vert: '{x: req_ch.pos_x, y: req_ch.pos_y, z: req_ch.pos_z,
                                      u: req_ch.tex_u, v: req_ch.tex_v,
                                      red: req_ch.color_red, green: req_ch.color_green,
                                      blue: req_ch.color_blue, alpha: req_ch.color_alpha}});
         end
      end
   end

   // vertex driver
   always @(negedge clock) begin
      if (reset) begin
         send_valid <= 1'b0;
      end else if (send_valid && !req_taken) begin
         // word still on offer
      end else if (send_gap != 0) begin
         send_valid <= 1'b0;
         send_gap   <= send_gap - 1;
      end else if (vertices_to_send.size() != 0) begin
         send_item  <= vertices_to_send.pop_front();
         send_valid <= 1'b1;
         send_gap   <= draw_gap(send_quiet);
      end else begin
         send_valid <= 1'b0;
      end
   end

   // result receiver, with one long hold to back up the input
   always @(negedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else if (hold_left != 0) begin
         take_ready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && words_seen >= HOLD_AFTER_WORDS) begin
         take_ready <= 1'b0;
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
      end else if (take_ready && !rsp_taken) begin
         // waiting for a word
      end else if (take_gap != 0) begin
         take_ready <= 1'b0;
         take_gap   <= take_gap - 1;
      end else begin
         take_ready <= 1'b1;
         take_gap   <= draw_gap(take_quiet);
      end
   end

   task automatic wait_drained();
      while (vertices_to_send.size() != 0 || send_valid || triangle_words_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type mode);
      wait_drained();
      @(negedge clock);
      csr_ch.valid         = 1'b1;
      csr_ch.assembly_mode = mode;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      mode_type phase_mode;
      int       phase_items;
      int       run_len;
      csr_ch.valid         = 1'b0;
      csr_ch.assembly_mode = MODE_NONE;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_mode(MODE_TRIANGLES);
      queue_vertex(1'b1, '0);
      queue_vertex(1'b0, '1);
      queue_vertex(1'b0, {VERTEX_WORDS{32'h5555_5555}});
      // restart in the middle of a triangle
      queue_vertex(1'b0, {VERTEX_WORDS{32'hAAAA_AAAA}});
      queue_vertex(1'b0, random_vertex());
      queue_vertex(1'b1, random_vertex());
      queue_vertex(1'b0, random_vertex());
      queue_vertex(1'b0, random_vertex());
      // mode rewrite drops a partial triangle
      queue_vertex(1'b0, random_vertex());
      queue_vertex(1'b0, random_vertex());
      write_mode(MODE_TRIANGLES);
      repeat (3) queue_vertex(1'b0, random_vertex());

      write_mode(MODE_QUADS);
      queue_vertex(1'b1, '1);
      repeat (3) queue_vertex(1'b0, random_vertex());

      write_mode(MODE_STRIP);
      queue_vertex(1'b1, random_vertex());
      repeat (4) queue_vertex(1'b0, random_vertex());

      write_mode(MODE_NONE);
      queue_vertex(1'b1, random_vertex());
      queue_vertex(1'b0, random_vertex());

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         phase_mode = mode_type'(p[1:0]);
         write_mode(phase_mode);
         if (phase_mode == MODE_NONE) begin
            repeat (12) queue_vertex(1'($urandom_range(0, 1)), random_vertex());
         end else begin
            phase_items = 0;
            while (phase_items < PHASE_VERTICES) begin
               if (phase_mode == MODE_QUADS)
                  run_len = 4;
               else if (phase_mode == MODE_TRIANGLES)
                  run_len = 3;
               else
                  run_len = $urandom_range(3, 12);
               for (int k = 0; k < run_len; k++) begin
                  if (k == 0)
                     queue_vertex(1'($urandom_range(0, 1)), random_vertex());
                  else
                     queue_vertex($urandom_range(0, 19) == 0, random_vertex());
               end
               phase_items += run_len;
            end
         end
      end
      wait_drained();

      $display("vertices taken %0d, triangle vertices checked %0d, mode writes %0d",
               vertices_taken, words_seen, modes_written);
      $display("all four modes run with restarts, mode rewrites and a long output hold");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
